### hw/rtl/ihex_pkg.sv
package ihex_pkg;

	localparam int MAX_RECORD_BYTES_DEF = 32;
	localparam int MAX_LINE_CHARS_DEF   = 255;

	localparam logic [1:0] FUNC_CHAR = 2'd0;
	localparam logic [1:0] FUNC_EOL  = 2'd1;
	localparam logic [1:0] FUNC_EOI  = 2'd2;

	localparam logic [1:0] LK_OTHER   = 2'd0;
	localparam logic [1:0] LK_INTEL   = 2'd1;
	localparam logic [1:0] LK_DUMP    = 2'd2;
	localparam logic [1:0] LK_COMMENT = 2'd3;

	localparam logic [2:0] ERR_NONE     = 3'd0;
	localparam logic [2:0] ERR_CHECKSUM = 3'd1;
	localparam logic [2:0] ERR_LENGTH   = 3'd2;
	localparam logic [2:0] ERR_NO_EOF   = 3'd3;
	localparam logic [2:0] ERR_TOO_LONG = 3'd4;

	localparam logic [7:0] REC_DATA = 8'h00;
	localparam logic [7:0] REC_EOF  = 8'h01;
	localparam logic [7:0] REC_SEG  = 8'h02;
	localparam logic [7:0] REC_LIN  = 8'h04;

	localparam logic RES_DATA   = 1'b0;
	localparam logic RES_REPORT = 1'b1;

	localparam logic [23:0] LINE_MAX = 24'hFFFFFF;
	localparam int          INTEL_MIN_CHARS = 11;
	localparam int          DUMP_MIN_CHARS  = 10;

	typedef struct packed {
		logic take_char;
		logic end_eval;
		logic finish;
		logic rd;
		logic emit;
		logic report;
	} ihex_cmd_t;

	typedef struct packed {
		logic has_emit;
		logic emit_last;
		logic out_free;
	} ihex_sts_t;

	// bit 4 set: not a hex digit
	function automatic logic [4:0] hexval(input logic [7:0] c);
		logic [4:0] v;
		v = 5'h10;
		if (c inside {[8'h30:8'h39]}) v = {1'b0, c[3:0]};
		else if (c inside {[8'h61:8'h66]}) v = 5'(c - 8'h57);
		else if (c inside {[8'h41:8'h46]}) v = 5'(c - 8'h37);
		return v;
	endfunction

endpackage

### hw/rtl/ihex_ram.sv
module ihex_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata <= mem[raddr];
	end
endmodule

### hw/rtl/ihex_ctrl.sv
module ihex_ctrl import ihex_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	input  logic [1:0] func,
	output logic       item_stall,
	input  ihex_sts_t  sts,
	output ihex_cmd_t  cmd
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_ENDL = 3'd1;
	localparam logic [2:0] S_RD   = 3'd2;
	localparam logic [2:0] S_OUT  = 3'd3;
	localparam logic [2:0] S_REP  = 3'd4;

	logic [2:0] state_q, state_n;

	assign item_stall = (state_q != S_IDLE);

	always_comb begin
		state_n = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					case (func)
						FUNC_CHAR: cmd.take_char = 1'b1;
						FUNC_EOL:  state_n = S_ENDL;
						FUNC_EOI:  state_n = S_REP;
						default:   ;
					endcase
				end
			end
			S_ENDL: begin
				cmd.end_eval = 1'b1;
				if (sts.has_emit) state_n = S_RD;
				else begin
					cmd.finish = 1'b1;
					state_n = S_IDLE;
				end
			end
			S_RD: begin
				cmd.rd = 1'b1;
				state_n = S_OUT;
			end
			S_OUT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.emit_last) begin
						cmd.finish = 1'b1;
						state_n = S_IDLE;
					end else state_n = S_RD;
				end
			end
			S_REP: begin
				if (sts.out_free) begin
					cmd.report = 1'b1;
					state_n = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_n;
	end
endmodule

### hw/rtl/ihex_dp.sv
module ihex_dp import ihex_pkg::*; #(
	parameter int MAX_RECORD_BYTES = MAX_RECORD_BYTES_DEF,
	parameter int MAX_LINE_CHARS   = MAX_LINE_CHARS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  ihex_cmd_t   cmd,
	output ihex_sts_t   sts,
	input  logic [7:0]  ch,
	output logic        result_valid,
	input  logic        result_stall,
	output logic        kind,
	output logic [31:0] address,
	output logic [7:0]  data,
	output logic [23:0] line_number,
	output logic [2:0]  error_code,
	output logic [23:0] error_line,
	output logic        last
);
	localparam int PW = $clog2(MAX_LINE_CHARS + 1);
	localparam int AW = $clog2(MAX_RECORD_BYTES);
	localparam int CW = $clog2(MAX_RECORD_BYTES + 1);
	localparam int XW = PW + 3;

	// per-line state
	logic [PW-1:0] pos_q;
	logic [1:0]    lkind_q;
	logic [4:0]    nib_q;
	logic [7:0]    csum_q, len_q, rtype_q;
	logic [15:0]   off_q;
	logic [CW-1:0] bcnt_q;
	logic [7:0]    b0_q, b1_q;
	logic [31:0]   daddr_q;
	logic          dstop_q;
	logic [1:0]    dph_q;
	logic [1:0]    chits_q;
	// file state
	logic [31:0]   base_q;
	logic          seg_q, eof_q;
	logic [23:0]   line_q, errl_q;
	logic [2:0]    errc_q;
	// emission
	logic [CW-1:0] n_q, i_q;
	logic          eseg_q, rdok_q;
	logic [15:0]   eoff_q;
	logic          ov_q;

	logic [4:0]    hv;
	logic [7:0]    pv;
	logic [1:0]    cls, kind_n;
	logic [XW-1:0] k, idx;
	logic          prt, active;
	logic          we;
	logic [AW-1:0] waddr;
	logic [7:0]    wdata, rdata;
	logic          intel_ok, dump_ok;
	logic [CW-1:0] n_c;
	logic [15:0]   bval;
	logic [7:0]    eofch;

	always_comb begin
		hv = hexval(ch);
		pv = nib_q[4] ? 8'h00 : {nib_q[3:0], (hv[4] ? 4'h0 : hv[3:0])};
		if (ch == 8'h3A) cls = LK_INTEL;
		else if (ch inside {[8'h30:8'h39]}) cls = LK_DUMP;
		else if (ch == 8'h3B) cls = LK_COMMENT;
		else cls = LK_OTHER;
		kind_n = (pos_q == '0) ? cls : lkind_q;
		k   = XW'(pos_q[PW-1:1]) - XW'(1);
		idx = k - XW'(4);
		prt = (ch > 8'h20) && (ch < 8'h80);
		active = cmd.take_char && (pos_q < PW'(MAX_LINE_CHARS));
		case (pos_q[1:0])
			2'd1:    eofch = 8'h45;
			2'd2:    eofch = 8'h4F;
			default: eofch = 8'h46;
		endcase
		we = 1'b0;
		waddr = idx[AW-1:0];
		wdata = pv;
		if (active && kind_n == LK_INTEL && pos_q != '0 && !pos_q[0] && k >= XW'(4)
				&& idx < XW'(len_q) && idx < XW'(MAX_RECORD_BYTES))
			we = 1'b1;
		if (active && kind_n == LK_DUMP && pos_q > PW'(8) && dph_q == 2'd2 && prt
				&& bcnt_q < CW'(MAX_RECORD_BYTES)) begin
			we = 1'b1;
			waddr = bcnt_q[AW-1:0];
		end
	end

	ihex_ram #(.WIDTH(8), .DEPTH(MAX_RECORD_BYTES)) u_buf (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (cmd.rd),
		.raddr (i_q[AW-1:0]),
		.rdata (rdata)
	);

	// end-of-line decision
	always_comb begin
		intel_ok = (lkind_q == LK_INTEL) && (pos_q >= PW'(INTEL_MIN_CHARS));
		dump_ok  = (lkind_q == LK_DUMP) && (pos_q >= PW'(DUMP_MIN_CHARS));
		n_c = '0;
		if (intel_ok && csum_q == 8'h00 && rtype_q == REC_DATA
				&& len_q <= 8'(MAX_RECORD_BYTES))
			n_c = CW'(len_q);
		else if (dump_ok)
			n_c = bcnt_q;
		bval = {(bcnt_q > CW'(0)) ? b0_q : 8'h00, (bcnt_q > CW'(1)) ? b1_q : 8'h00};
	end

	assign sts.has_emit  = (n_c != '0);
	assign sts.emit_last = ({1'b0, i_q} + (CW+1)'(1)) == {1'b0, n_q};
	assign sts.out_free  = !ov_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0; lkind_q <= LK_OTHER; nib_q <= '0; csum_q <= '0; len_q <= '0;
			off_q <= '0; rtype_q <= '0; bcnt_q <= '0; daddr_q <= '0; dstop_q <= 1'b0;
			dph_q <= '0; chits_q <= '0; b0_q <= '0; b1_q <= '0;
			base_q <= '0; seg_q <= 1'b0; eof_q <= 1'b0; line_q <= 24'd1;
			errl_q <= '0; errc_q <= ERR_NONE;
			n_q <= '0; i_q <= '0; eseg_q <= 1'b0; eoff_q <= '0; rdok_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (active) begin
				pos_q <= pos_q + PW'(1);
				if (pos_q == '0) lkind_q <= cls;
				case (kind_n)
					LK_INTEL: begin
						if (pos_q != '0) begin
							if (pos_q[0]) nib_q <= hv;
							else begin
								if (k == XW'(0)) len_q <= pv;
								else if (k == XW'(1)) off_q[15:8] <= pv;
								else if (k == XW'(2)) off_q[7:0] <= pv;
								else if (k == XW'(3)) rtype_q <= pv;
								if (k <= XW'(len_q) + XW'(4)) csum_q <= csum_q + pv;
							end
						end
					end
					LK_DUMP: begin
						if (pos_q < PW'(8)) begin
							if (!dstop_q) begin
								if (ch == 8'h3A) dstop_q <= 1'b1;
								else begin
									daddr_q <= {daddr_q[27:0], (hv[4] ? 4'h0 : hv[3:0])};
									if (hv[4]) dstop_q <= 1'b1;
								end
							end
						end else if (pos_q == PW'(8)) begin
							if (ch != 8'h3A) lkind_q <= LK_OTHER;
						end else if (dph_q == 2'd0 && ch == 8'h20) begin
							dph_q <= 2'd1;
						end else if (dph_q <= 2'd1) begin
							if (prt) begin
								nib_q <= hv;
								dph_q <= 2'd2;
							end else dph_q <= 2'd3;
						end else if (dph_q == 2'd2) begin
							if (prt && bcnt_q < CW'(MAX_RECORD_BYTES))
								dph_q <= (bcnt_q + CW'(1) >= CW'(MAX_RECORD_BYTES))
									? 2'd3 : 2'd0;
							else dph_q <= 2'd3;
						end
					end
					LK_COMMENT: begin
						if (pos_q != '0 && pos_q <= PW'(3)
								&& PW'(chits_q) == pos_q - PW'(1) && ch == eofch)
							chits_q <= chits_q + 2'd1;
					end
					default: ;
				endcase
			end
			if (we) begin
				bcnt_q <= CW'(waddr) + CW'(1);
				// first two bytes kept for base address records
				if (waddr == AW'(0)) b0_q <= wdata;
				if (waddr == AW'(1)) b1_q <= wdata;
			end

			if (cmd.end_eval) begin
				n_q <= n_c;
				i_q <= '0;
				eseg_q <= seg_q && intel_ok;
				eoff_q <= dump_ok ? 16'h0000 : off_q;
				if (intel_ok) begin
					if (csum_q != 8'h00) begin
						if (errl_q == '0) begin errl_q <= line_q; errc_q <= ERR_CHECKSUM; end
					end else if (rtype_q == REC_DATA) begin
						if (len_q > 8'(MAX_RECORD_BYTES) && errl_q == '0) begin
							errl_q <= line_q; errc_q <= ERR_TOO_LONG;
						end
					end else if (rtype_q == REC_EOF) begin
						eof_q <= 1'b1;
					end else if (rtype_q == REC_SEG || rtype_q == REC_LIN) begin
						if (len_q != 8'd2) begin
							if (errl_q == '0) begin errl_q <= line_q; errc_q <= ERR_LENGTH; end
						end else begin
							seg_q  <= (rtype_q == REC_SEG);
							base_q <= (rtype_q == REC_SEG) ? {12'h000, bval, 4'h0}
								: {bval, 16'h0000};
						end
					end
				end else if (dump_ok) begin
					base_q <= daddr_q;
				end else if (lkind_q == LK_COMMENT && chits_q == 2'd3) begin
					eof_q <= 1'b1;
				end
			end

			if (cmd.rd) rdok_q <= (i_q < bcnt_q);
			if (cmd.emit) i_q <= i_q + CW'(1);

			if (cmd.finish || cmd.report) begin
				pos_q <= '0; lkind_q <= LK_OTHER; nib_q <= '0; csum_q <= '0; len_q <= '0;
				off_q <= '0; rtype_q <= '0; bcnt_q <= '0; daddr_q <= '0; dstop_q <= 1'b0;
				dph_q <= '0; chits_q <= '0;
			end
			if (cmd.finish && line_q != LINE_MAX) line_q <= line_q + 24'd1;
			if (cmd.report) begin
				base_q <= '0; seg_q <= 1'b0; eof_q <= 1'b0; line_q <= 24'd1;
				errl_q <= '0; errc_q <= ERR_NONE;
			end

			if (cmd.emit || cmd.report) ov_q <= 1'b1;
			else if (ov_q && !result_stall) ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			kind        <= RES_DATA;
			address     <= eseg_q ? base_q + {16'h0000, eoff_q + 16'(i_q)}
				: base_q + {16'h0000, eoff_q} + 32'(i_q);
			data        <= rdok_q ? rdata : 8'h00;
			line_number <= line_q;
			error_code  <= ERR_NONE;
			error_line  <= '0;
			last        <= sts.emit_last;
		end else if (cmd.report) begin
			kind        <= RES_REPORT;
			address     <= '0;
			data        <= 8'h00;
			line_number <= line_q;
			if (errl_q != '0) begin
				error_code <= errc_q;
				error_line <= errl_q;
			end else if (!eof_q) begin
				error_code <= ERR_NO_EOF;
				error_line <= line_q;
			end else begin
				error_code <= ERR_NONE;
				error_line <= '0;
			end
			last        <= 1'b1;
		end
	end

	assign result_valid = ov_q;

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		i_q <= n_q) else $error("emit index past count");
	a_bcnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		bcnt_q <= CW'(MAX_RECORD_BYTES)) else $error("byte count overflow");
	a_report_resets: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.report |=> (line_q == 24'd1 && errl_q == '0 && !eof_q))
		else $error("report did not restart the file state");
endmodule

### hw/rtl/intel_hex_record_parser_core.sv
// Intel HEX / hex-dump line parser. Feed characters with func=0, an end-of-line request
// (func=1) after each line and an end-of-input request (func=2) after the file. A character
// request does not stall the input. End of line evaluates the line, then each emitted byte
// goes through a buffer RAM read and then the output register, and the input stays stalled
// until the last byte of the line is emitted, and longer under output back-pressure. End
// of input returns one report (first error line and code, or no-EOF) and restarts the parser.
module intel_hex_record_parser_core import ihex_pkg::*; #(
	parameter int MAX_RECORD_BYTES = MAX_RECORD_BYTES_DEF,
	parameter int MAX_LINE_CHARS   = MAX_LINE_CHARS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [1:0]  func,
	input  logic [7:0]  ch,
	output logic        result_valid,
	input  logic        result_stall,
	output logic        kind,
	output logic [31:0] address,
	output logic [7:0]  data,
	output logic [23:0] line_number,
	output logic [2:0]  error_code,
	output logic [23:0] error_line,
	output logic        last
);
	ihex_cmd_t cmd;
	ihex_sts_t sts;

	ihex_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.func       (func),
		.item_stall (item_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	ihex_dp #(
		.MAX_RECORD_BYTES (MAX_RECORD_BYTES),
		.MAX_LINE_CHARS   (MAX_LINE_CHARS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.ch           (ch),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.kind         (kind),
		.address      (address),
		.data         (data),
		.line_number  (line_number),
		.error_code   (error_code),
		.error_line   (error_line),
		.last         (last)
	);
endmodule
